### design/mie_pkg.sv
`default_nettype none

package mie_pkg;

    localparam int MEMORY_WORDS = 1024;
    localparam int ADDR_W       = $clog2(MEMORY_WORDS);
    localparam int WORD_W       = 64;
    localparam int ACT_W        = 2;
    localparam int NUM_OPS      = 8;
    localparam int OP_IDX_W     = $clog2(NUM_OPS);
    localparam int IN_W         = ((ACT_W + 2 * WORD_W + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * WORD_W + 1 + 7) / 8) * 8;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [ACT_W-1:0]    t_action;
    typedef logic [OP_IDX_W-1:0] t_opsel;
    typedef logic [2:0]          t_rsel;
    typedef logic [2:0]          t_wdsel;
    typedef logic [2:0]          t_pcsel;

    localparam t_action ACT_WRITE  = 2'd0;
    localparam t_action ACT_READ   = 2'd1;
    localparam t_action ACT_EXEC   = 2'd2;
    localparam t_action ACT_SET_PC = 2'd3;

    localparam t_opsel OP_COPY = 3'd0;
    localparam t_opsel OP_NOT  = 3'd1;
    localparam t_opsel OP_OR   = 3'd2;
    localparam t_opsel OP_AND  = 3'd3;
    localparam t_opsel OP_JEQ  = 3'd4;
    localparam t_opsel OP_IDLE = 3'd5;
    localparam t_opsel OP_EXIT = 3'd6;
    localparam t_opsel OP_JEQI = 3'd7;

    localparam t_rsel RA_IN   = 3'd0;
    localparam t_rsel RA_PC   = 3'd1;
    localparam t_rsel RA_PC1  = 3'd2;
    localparam t_rsel RA_PC2  = 3'd3;
    localparam t_rsel RA_PC3  = 3'd4;
    localparam t_rsel RA_DOUT = 3'd5;

    localparam logic WA_IN   = 1'b0;
    localparam logic WA_DOUT = 1'b1;

    localparam t_wdsel WD_IN    = 3'd0;
    localparam t_wdsel WD_A     = 3'd1;
    localparam t_wdsel WD_NOT_A = 3'd2;
    localparam t_wdsel WD_OR    = 3'd3;
    localparam t_wdsel WD_AND   = 3'd4;

    localparam t_pcsel PC_IN    = 3'd0;
    localparam t_pcsel PC_PLUS1 = 3'd1;
    localparam t_pcsel PC_PLUS3 = 3'd2;
    localparam t_pcsel PC_PLUS4 = 3'd3;
    localparam t_pcsel PC_DOUT  = 3'd4;

    typedef struct packed {
        logic   latch_in;
        logic   rd_en;
        t_rsel  rd_sel;
        logic   wr_en;
        logic   wa_sel;
        t_wdsel wd_sel;
        logic   pc_en;
        t_pcsel pc_sel;
        logic   a_en;
        logic   b_en;
        logic   sel_en;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        t_opsel  op_now;
        t_opsel  op_sel;
        logic    a_eq_b;
    } t_status;

endpackage

`default_nettype wire

### design/mie_datapath.sv
`default_nettype none

module mie_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mie_pkg::t_cmd           i_cmd,
    output mie_pkg::t_status             o_status,
    input  wire mie_pkg::t_action        i_action,
    input  wire mie_pkg::t_word          i_word_address,
    input  wire mie_pkg::t_word          i_write_data,
    input  wire                          i_cfg_we,
    input  wire [mie_pkg::OP_IDX_W-1:0]  i_cfg_index,
    input  wire mie_pkg::t_word          i_cfg_data,
    output mie_pkg::t_word               o_read_data,
    output mie_pkg::t_word               o_counter_after,
    output logic                         o_at_exit
);
    import mie_pkg::*;

    t_word   r_mem [MEMORY_WORDS];
    t_word   r_dout;
    t_word   r_opcode [NUM_OPS];
    t_action r_action;
    t_word   r_addr;
    t_word   r_wdata;
    t_word   r_pc;
    t_word   n_pc;
    t_word   r_a;
    t_word   r_b;
    t_opsel  r_sel;
    t_opsel  op_now;
    t_addr   rd_addr;
    t_addr   wr_addr;
    t_word   wr_data;
    t_word   r_out_rd;
    t_word   r_out_pc;
    logic    r_out_exit;

    // first matching opcode register wins; no match behaves as idle
    always_comb begin
        op_now = OP_IDLE;
        for (int i = NUM_OPS - 1; i >= 0; i--) begin
            if (r_dout == r_opcode[i]) begin
                op_now = t_opsel'(i);
            end
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RA_IN:   rd_addr = r_addr[ADDR_W-1:0];
            RA_PC:   rd_addr = r_pc[ADDR_W-1:0];
            RA_PC1:  rd_addr = r_pc[ADDR_W-1:0] + t_addr'(1);
            RA_PC2:  rd_addr = r_pc[ADDR_W-1:0] + t_addr'(2);
            RA_PC3:  rd_addr = r_pc[ADDR_W-1:0] + t_addr'(3);
            RA_DOUT: rd_addr = r_dout[ADDR_W-1:0];
            default: rd_addr = r_dout[ADDR_W-1:0];
        endcase
    end

    assign wr_addr = (i_cmd.wa_sel == WA_DOUT) ? r_dout[ADDR_W-1:0] : r_addr[ADDR_W-1:0];

    always_comb begin
        case (i_cmd.wd_sel)
            WD_IN:    wr_data = r_wdata;
            WD_A:     wr_data = r_a;
            WD_NOT_A: wr_data = ~r_a;
            WD_OR:    wr_data = r_a | r_b;
            WD_AND:   wr_data = r_a & r_b;
            default:  wr_data = r_wdata;
        endcase
    end

    always_comb begin
        case (i_cmd.pc_sel)
            PC_IN:    n_pc = r_addr;
            PC_PLUS1: n_pc = r_pc + t_word'(1);
            PC_PLUS3: n_pc = r_pc + t_word'(3);
            PC_PLUS4: n_pc = r_pc + t_word'(4);
            PC_DOUT:  n_pc = r_dout;
            default:  n_pc = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_dout <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            for (int i = 0; i < NUM_OPS; i++) begin
                r_opcode[i] <= t_word'(i);
            end
        end else begin
            if (i_cmd.pc_en) begin
                r_pc <= n_pc;
            end
            if (i_cfg_we) begin
                r_opcode[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= i_action;
            r_addr   <= i_word_address;
            r_wdata  <= i_write_data;
        end
        if (i_cmd.sel_en) begin
            r_sel <= op_now;
        end
        if (i_cmd.a_en) begin
            r_a <= r_dout;
        end
        if (i_cmd.b_en) begin
            r_b <= r_dout;
        end
        if (i_cmd.out_load) begin
            r_out_rd   <= (r_action == ACT_READ) ? r_dout : '0;
            r_out_pc   <= r_pc;
            r_out_exit <= (r_action == ACT_EXEC) && (r_sel == OP_EXIT);
        end
    end

    assign o_status.action = r_action;
    assign o_status.op_now = op_now;
    assign o_status.op_sel = r_sel;
    assign o_status.a_eq_b = (r_a == r_b);

    assign o_read_data     = r_out_rd;
    assign o_counter_after = r_out_pc;
    assign o_at_exit       = r_out_exit;

endmodule

`default_nettype wire

### design/mie_ctrl.sv
`default_nettype none

module mie_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire mie_pkg::t_status i_status,
    output mie_pkg::t_cmd       o_cmd
);
    import mie_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_RDWAIT   = 4'd2;
    localparam logic [3:0] S_OP       = 4'd3;
    localparam logic [3:0] S_P1       = 4'd4;
    localparam logic [3:0] S_A        = 4'd5;
    localparam logic [3:0] S_P2       = 4'd6;
    localparam logic [3:0] S_B        = 4'd7;
    localparam logic [3:0] S_P3       = 4'd8;
    localparam logic [3:0] S_T        = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RA_IN;
        o_cmd.wa_sel = WA_IN;
        o_cmd.wd_sel = WD_IN;
        o_cmd.pc_sel = PC_IN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.action)
                    ACT_WRITE: begin
                        o_cmd.wr_en = 1'b1;
                        n_state     = S_DONE;
                    end
                    ACT_READ: begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_RDWAIT;
                    end
                    ACT_EXEC: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_PC;
                        n_state      = S_OP;
                    end
                    default: begin
                        o_cmd.pc_en = 1'b1;
                        n_state     = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_state = S_DONE;
            end
            S_OP: begin
                o_cmd.sel_en = 1'b1;
                if (i_status.op_now == OP_IDLE) begin
                    o_cmd.pc_en  = 1'b1;
                    o_cmd.pc_sel = PC_PLUS1;
                    n_state      = S_DONE;
                end else if (i_status.op_now == OP_EXIT) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PC1;
                    n_state      = S_P1;
                end
            end
            S_P1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_DOUT;
                n_state      = S_A;
            end
            S_A: begin
                o_cmd.a_en   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_PC2;
                n_state      = S_P2;
            end
            S_P2: begin
                if (i_status.op_sel == OP_COPY || i_status.op_sel == OP_NOT) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wa_sel = WA_DOUT;
                    o_cmd.wd_sel = (i_status.op_sel == OP_NOT) ? WD_NOT_A : WD_A;
                    o_cmd.pc_en  = 1'b1;
                    o_cmd.pc_sel = PC_PLUS3;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_DOUT;
                    n_state      = S_B;
                end
            end
            S_B: begin
                o_cmd.b_en   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_PC3;
                n_state      = S_P3;
            end
            S_P3: begin
                o_cmd.pc_en  = 1'b1;
                o_cmd.pc_sel = PC_PLUS4;
                n_state      = S_DONE;
                if (i_status.op_sel == OP_OR || i_status.op_sel == OP_AND) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wa_sel = WA_DOUT;
                    o_cmd.wd_sel = (i_status.op_sel == OP_AND) ? WD_AND : WD_OR;
                end else if (i_status.a_eq_b) begin
                    if (i_status.op_sel == OP_JEQI) begin
                        o_cmd.pc_en  = 1'b0;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_DOUT;
                        n_state      = S_T;
                    end else begin
                        o_cmd.pc_sel = PC_DOUT;
                    end
                end
            end
            S_T: begin
                o_cmd.pc_en  = 1'b1;
                o_cmd.pc_sel = PC_DOUT;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/memory_indirect_instruction_executor.sv
`default_nettype none
// Items are handled one at a time. Write and set-counter pass the fewest controller states,
// then read, idle and exit, then copy and not, then or, and and the direct jump; a taken
// indirect jump passes the most. The input is ready again in the cycle after a result is loaded;
// execution reads its operands one after another through the single read port of the word store.
// Reset (synchronous, active low) clears the controller, the counter and the opcode
// registers to their defaults; the word store is not cleared.

module memory_indirect_instruction_executor (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // action[1:0], word_address[65:2], write_data[129:66], zero pad
    input  wire [mie_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // read_data[63:0], counter_after[127:64], at_exit[128], zero pad
    output logic [mie_pkg::OUT_W-1:0]  m_axis_tdata,
    input  wire                        i_cfg_we,
    input  wire [mie_pkg::OP_IDX_W-1:0] i_cfg_index,
    input  wire [mie_pkg::WORD_W-1:0]  i_cfg_data
);
    import mie_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_word   read_data;
    t_word   counter_after;
    logic    at_exit;

    mie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mie_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (s_axis_tdata[ACT_W-1:0]),
        .i_word_address  (s_axis_tdata[ACT_W+WORD_W-1:ACT_W]),
        .i_write_data    (s_axis_tdata[ACT_W+2*WORD_W-1:ACT_W+WORD_W]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_read_data     (read_data),
        .o_counter_after (counter_after),
        .o_at_exit       (at_exit)
    );

    assign m_axis_tdata = {{(OUT_W - 2 * WORD_W - 1){1'b0}}, at_exit, counter_after, read_data};

endmodule

`default_nettype wire

### design/mie_checker.sv
`default_nettype none

module mie_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       s_axis_tvalid,
    input wire                       s_axis_tready,
    input wire                       m_axis_tvalid,
    input wire                       m_axis_tready,
    input wire [mie_pkg::OUT_W-1:0]  m_axis_tdata
);
    import mie_pkg::*;

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: busy right after an input transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // exit comes only from execution, which returns no read word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2*WORD_W] |-> m_axis_tdata[WORD_W-1:0] == '0)
        else $error("exit result carries read data");

endmodule

bind memory_indirect_instruction_executor mie_checker u_mie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/mie_result_check.sv
module mie_result_check (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    input  wire                          s_axis_tready,
    // action[1:0], word_address[65:2], write_data[129:66], zero pad
    input  wire [mie_pkg::IN_W-1:0]      s_axis_tdata,
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    // read_data[63:0], counter_after[127:64], at_exit[128], zero pad
    input  wire [mie_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire                          i_cfg_we,
    input  wire [mie_pkg::OP_IDX_W-1:0]  i_cfg_index,
    input  wire [mie_pkg::WORD_W-1:0]    i_cfg_data,
    output int                           o_pending,
    output int                           o_failures
);
    import mie_pkg::*;

    typedef struct packed {
        logic  exited;
        t_word counter;
        t_word read_data;
    } t_outcome;

    t_word    word_store [MEMORY_WORDS];
    t_word    pc_model;
    t_word    opcode_model [NUM_OPS];
    t_outcome outcome_q [$];
    int       failures;

    function automatic t_word fetch_word(t_word a);
        return word_store[a % MEMORY_WORDS];
    endfunction

    function automatic void store_word(t_word a, t_word v);
        word_store[a % MEMORY_WORDS] = v;
    endfunction

    function automatic t_word execute_at_counter(output logic exited);
        t_word  op_word;
        t_word  a;
        t_word  b;
        t_opsel sel;
        logic   matched;
        op_word = fetch_word(pc_model);
        exited  = 1'b0;
        matched = 1'b0;
        sel     = OP_IDLE;
        for (int i = NUM_OPS - 1; i >= 0; i--) begin
            if (op_word == opcode_model[i]) begin
                matched = 1'b1;
                sel     = t_opsel'(i);
            end
        end
        if (!matched) return pc_model + 1;
        a = fetch_word(fetch_word(pc_model + 1));
        b = fetch_word(fetch_word(pc_model + 2));
        case (sel)
            OP_COPY: begin
                store_word(fetch_word(pc_model + 2), a);
                return pc_model + 3;
            end
            OP_NOT: begin
                store_word(fetch_word(pc_model + 2), ~a);
                return pc_model + 3;
            end
            OP_OR: begin
                store_word(fetch_word(pc_model + 3), a | b);
                return pc_model + 4;
            end
            OP_AND: begin
                store_word(fetch_word(pc_model + 3), a & b);
                return pc_model + 4;
            end
            OP_JEQ: begin
                return (a == b) ? fetch_word(pc_model + 3) : pc_model + 4;
            end
            OP_EXIT: begin
                exited = 1'b1;
                return pc_model;
            end
            OP_JEQI: begin
                return (a == b) ? fetch_word(fetch_word(pc_model + 3)) : pc_model + 4;
            end
            default: begin
                return pc_model + 1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_word    addr;
        t_word    data;
        logic     exit_flag;
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            pc_model = '0;
            for (int i = 0; i < NUM_OPS; i++) opcode_model[i] = t_word'(i);
            outcome_q.delete();
        end else begin
            if (i_cfg_we) opcode_model[i_cfg_index] = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                addr      = s_axis_tdata[ACT_W +: WORD_W];
                data      = s_axis_tdata[ACT_W + WORD_W +: WORD_W];
                exit_flag = 1'b0;
                want      = '0;
                case (t_action'(s_axis_tdata[ACT_W-1:0]))
                    ACT_WRITE:  store_word(addr, data);
                    ACT_READ:   want.read_data = fetch_word(addr);
                    ACT_EXEC:   pc_model = execute_at_counter(exit_flag);
                    default:    pc_model = addr;
                endcase
                want.exited  = exit_flag;
                want.counter = pc_model;
                outcome_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_outcome'(m_axis_tdata[2*WORD_W:0]);
                if (outcome_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result at %0t: read_data %h counter %h exit %b",
                                 $realtime, got.read_data, got.counter, got.exited);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.read_data !== want.read_data || got.counter !== want.counter ||
                        got.exited !== want.exited) begin
                        failures++;
                        if (failures <= 10) begin
                            $write("mismatch at %0t (expected/actual): read_data %h/%h ",
                                   $realtime, want.read_data, got.read_data);
                            $display("counter %h/%h exit %b/%b", want.counter, got.counter,
                                     want.exited, got.exited);
                        end
                    end
                end
            end
        end
        o_pending  <= outcome_q.size();
        o_failures <= failures;
    end

endmodule

### bench/testbench.sv
module testbench;
    import mie_pkg::*;

    localparam int    RANDOM_ITEMS = 950;
    localparam int    IDLE_PCT     = 31;
    localparam t_word CHAIN        = 64'd100;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [OP_IDX_W-1:0]  i_cfg_index   = '0;
    logic [WORD_W-1:0]    i_cfg_data    = '0;

    int    pending;
    int    failures;
    bit    steady = 1'b0;
    t_word opcode_value [NUM_OPS];
    int    sent_by_action [4];
    int    items_sent;
    int    programs_run;

    memory_indirect_instruction_executor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    mie_result_check result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_failures     (failures)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(t_action act, t_word addr, t_word data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({data, addr, act});
        do @(posedge i_clk); while (!s_axis_tready);
        sent_by_action[act]++;
        items_sent++;
    endtask

    // drop valid and let every outstanding transfer come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_opcode_registers();
        for (int i = 0; i < NUM_OPS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= OP_IDX_W'(i);
            i_cfg_data  <= opcode_value[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // kind NUM_OPS lays down an opcode word that matches no register
    task automatic run_program(int kind, t_word base, int steps);
        t_word op_word;
        t_word src_a;
        t_word src_b;
        t_word dest;
        t_word shared;
        bit    clash;
        if (kind < NUM_OPS) begin
            op_word = opcode_value[kind];
        end else begin
            do begin
                op_word = rand_word();
                clash   = 1'b0;
                foreach (opcode_value[i]) begin
                    if (op_word == opcode_value[i]) clash = 1'b1;
                end
            end while (clash);
        end
        src_a = rand_word();
        src_b = ($urandom_range(0, 2) == 0) ? src_a : rand_word();
        dest  = rand_word();
        send_item(ACT_WRITE, base, op_word);
        send_item(ACT_WRITE, base + 1, src_a);
        send_item(ACT_WRITE, base + 2, src_b);
        send_item(ACT_WRITE, base + 3, dest);
        if ($urandom_range(0, 1) == 1) begin
            shared = rand_word();
            send_item(ACT_WRITE, src_a, shared);
            send_item(ACT_WRITE, src_b, ($urandom_range(0, 1) == 1) ? shared : rand_word());
        end
        send_item(ACT_SET_PC, base, rand_word());
        repeat (steps) send_item(ACT_EXEC, rand_word(), rand_word());
        if ($urandom_range(0, 1) == 1) begin
            send_item(ACT_READ, src_b, rand_word());
            send_item(ACT_READ, dest, rand_word());
        end
        programs_run++;
    endtask

    initial begin
        int    first;
        t_word base;
        foreach (opcode_value[i]) opcode_value[i] = t_word'(i);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole store so that no pointer ever lands on an unwritten word
        for (int a = 0; a < MEMORY_WORDS; a++)
            send_item(ACT_WRITE, rand_word() / MEMORY_WORDS * MEMORY_WORDS + a, rand_word());

        send_item(ACT_WRITE, '1, '1);
        send_item(ACT_READ, '1, '0);
        send_item(ACT_WRITE, 64'h8000_0000_0000_0000, '0);
        send_item(ACT_READ, 64'h8000_0000_0000_0400, '1);
        send_item(ACT_SET_PC, '1, '0);
        send_item(ACT_EXEC, '0, '1);

        send_item(ACT_WRITE, CHAIN + 0, opcode_value[OP_COPY]);
        send_item(ACT_WRITE, CHAIN + 3, opcode_value[OP_NOT]);
        send_item(ACT_WRITE, CHAIN + 6, opcode_value[OP_OR]);
        send_item(ACT_WRITE, CHAIN + 10, opcode_value[OP_AND]);
        send_item(ACT_WRITE, CHAIN + 14, opcode_value[OP_JEQ]);
        send_item(ACT_WRITE, CHAIN + 18, opcode_value[OP_IDLE]);
        send_item(ACT_WRITE, CHAIN + 19, 64'h0123_4567_89AB_CDEF);
        send_item(ACT_WRITE, CHAIN + 20, opcode_value[OP_JEQI]);
        send_item(ACT_WRITE, CHAIN + 24, opcode_value[OP_EXIT]);
        send_item(ACT_SET_PC, CHAIN, rand_word());
        repeat (9) send_item(ACT_EXEC, rand_word(), rand_word());

        first = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: opcode_value = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                                        64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                        64'h1, 64'hAAAA_AAAA_AAAA_AAAA,
                                        64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFE};
                    2: begin
                        foreach (opcode_value[i]) opcode_value[i] = rand_word();
                        opcode_value[OP_JEQI] = opcode_value[OP_JEQ];
                        opcode_value[OP_EXIT] = opcode_value[OP_COPY];
                        opcode_value[OP_IDLE] = opcode_value[OP_OR];
                    end
                    default: foreach (opcode_value[i]) opcode_value[i] = rand_word();
                endcase
                write_opcode_registers();
            end
            steady = (phase == 1);
            while (items_sent - first < (phase + 1) * RANDOM_ITEMS / 4) begin
                if ($urandom_range(0, 9) < 7) begin
                    base = ($urandom_range(0, 7) == 0) ? ~t_word'($urandom_range(0, 4))
                                                       : rand_word();
                    run_program($urandom_range(0, NUM_OPS), base, $urandom_range(1, 3));
                end else begin
                    send_item(t_action'($urandom_range(0, 3)), rand_word(), rand_word());
                end
            end
        end
        steady = 1'b0;

        wait_drained();
        $display("covered %0d transfers: %0d writes, %0d reads, %0d executes, %0d counter loads",
                 items_sent, sent_by_action[ACT_WRITE], sent_by_action[ACT_READ],
                 sent_by_action[ACT_EXEC], sent_by_action[ACT_SET_PC]);
        $display("%0d generated programs under four opcode settings, %0d result errors",
                 programs_run, failures);
        if (failures == 0 && pending == 0) begin
            $display("PASS memory_indirect_instruction_executor");
        end else begin
            $display("FAIL memory_indirect_instruction_executor");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL memory_indirect_instruction_executor");
        $finish;
    end

endmodule
